// ----- src/vqdm_pkg.sv -----
// ----------------------------------------------------------------------------
// vqdm_pkg: shared definitions for the virtqueue descriptor manager
// Opcodes, status codes, descriptor and used-entry layouts.
// ----------------------------------------------------------------------------
package vqdm_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 256;
   localparam logic [15:0] CSR_SIZE_RESET = 16'd256;
   localparam logic [15:0] END_MARK = 16'hFFFF;
   localparam logic [15:0] FLAG_NEXT = 16'h0001;

   localparam int DESC_W = 128;   // {addr, len, flags, next}
   localparam int USED_W = 48;    // {id, len}

   typedef enum logic [2:0] {
      OP_INIT     = 3'd0,
      OP_ADD_ONE  = 3'd1,
      OP_ADD_PAIR = 3'd2,
      OP_FREE     = 3'd3,
      OP_COMPLETE = 3'd4,
      OP_TAKE     = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_FREE  = 3'd1,
      ST_NO_USED  = 3'd2,
      ST_BAD_SIZE = 3'd3,
      ST_BAD_ID   = 3'd4,
      ST_NO_INIT  = 3'd5
   } status_type;

endpackage

// ----- src/virtqueue_descriptor_manager_top.sv -----
// ----------------------------------------------------------------------------
// virtqueue_descriptor_manager_top: split virtqueue descriptor manager
// Descriptor table with LIFO free list, available ring and used ring.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, req_*, busy             beat when start && !busy
//  response  rsp_valid, rsp_*               one-cycle strobe, no backpressure
//  csr       csr_valid, csr_data, csr_ready beat when csr_valid && csr_ready
//
//  Steps: complete, unknown and rejected items answer from idle; add single and
//  take used pass ADD1 or TAKE (one descriptor or used-ring read); add pair passes
//  PAIR_B to PAIR_D (two dependent free-list reads); free loops FREE_RD, FREE_CHK
//  per descriptor walked; init sweeps the descriptor RAM one entry a cycle.
//  Reset clears control state; table contents stay undefined until init.
//  busy is high while an item is at work; the receiver cannot stall.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_manager_top
   import vqdm_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [63:0] req_first_addr,
   input  logic [31:0] req_first_len,
   input  logic [15:0] req_first_flags,
   input  logic [63:0] req_second_addr,
   input  logic [31:0] req_second_len,
   input  logic [15:0] req_second_flags,
   input  logic [15:0] req_desc_id,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_result_id,
   output logic [31:0] rsp_result_len,
   output logic        rsp_used_pending,
   output logic [8:0]  rsp_free_left,
   output logic [15:0] rsp_avail_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SWEEP, S_ADD1, S_PAIR_B, S_PAIR_C, S_PAIR_D,
      S_FREE_RD, S_FREE_CHK, S_TAKE
   } state_type;

   state_type      state_ff;
   logic [15:0]    req_size_ff;
   logic [CW-1:0]  size_ff, init_size_ff, total_ff, step_ff;
   logic [AW-1:0]  head_ff, cur_ff, h_ff, t_ff;
   logic [15:0]    avail_pos_ff, used_pos_ff, cons_pos_ff;
   logic [63:0]    a1_ff, a2_ff;
   logic [31:0]    l1_ff, l2_ff;
   logic [15:0]    f1_ff, f2_ff;
   logic           rsp_valid_ff;
   status_type     rsp_status_ff;
   logic [15:0]    rsp_id_ff;
   logic [31:0]    rsp_len_ff;

   logic                desc_we, avail_we, used_we;
   logic [AW-1:0]       desc_waddr, desc_raddr, avail_waddr, used_waddr, used_raddr;
   logic [DESC_W-1:0]   desc_wdata, desc_rdata;
   logic [15:0]         avail_wdata;
   logic [USED_W-1:0]   used_wdata, used_rdata;
   logic [15:0]         avail_unused;

   logic           accept;
   logic [AW-1:0]  mask;
   logic [15:0]    rd_next, nx_t, pending;
   logic           nx_ok, nxt_ok, size_pow2;
   logic [AW-1:0]  t_sel;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign mask      = AW'(size_ff - CW'(1));
   assign rd_next   = desc_rdata[15:0];
   assign nx_ok     = {1'b0, rd_next} < 17'(size_ff);
   assign t_sel     = nx_ok ? AW'(rd_next) : '0;
   // the second take sees the next field the first take just cleared
   assign nx_t      = (t_ff == h_ff) ? 16'd0 : rd_next;
   assign nxt_ok    = {1'b0, nx_t} < 17'(size_ff);
   assign pending   = used_pos_ff - cons_pos_ff;
   assign size_pow2 = (req_size_ff != 16'd0) &&
                      ((req_size_ff & (req_size_ff - 16'd1)) == 16'd0);

   always_comb begin
      desc_we    = 1'b0;
      desc_waddr = cur_ff;
      desc_wdata = '0;
      desc_raddr = head_ff;
      avail_we   = 1'b0;
      avail_waddr = avail_pos_ff[AW-1:0] & mask;
      avail_wdata = 16'(head_ff);
      used_we    = 1'b0;
      used_waddr = used_pos_ff[AW-1:0] & mask;
      used_wdata = {req_desc_id, req_first_len};
      used_raddr = cons_pos_ff[AW-1:0] & mask;
      unique case (state_ff)
         S_IDLE: begin
            used_we = accept && (req_opcode == OP_COMPLETE) && (size_ff != '0) &&
                      ({1'b0, pending} < 17'(size_ff));
         end
         S_SWEEP: begin
            desc_we    = 1'b1;
            desc_wdata[15:0] = (CW'(cur_ff) == init_size_ff - CW'(1)) ?
                               END_MARK : 16'(cur_ff) + 16'd1;
         end
         S_ADD1: begin
            desc_we    = 1'b1;
            desc_waddr = head_ff;
            desc_wdata = {a1_ff, l1_ff, f1_ff, 16'd0};
            avail_we   = 1'b1;
         end
         S_PAIR_B: begin
            desc_raddr = t_sel;
         end
         S_PAIR_C: begin
            desc_we    = 1'b1;
            desc_waddr = h_ff;
            desc_wdata = {a1_ff, l1_ff, f1_ff | FLAG_NEXT, 16'(t_ff)};
         end
         S_PAIR_D: begin
            desc_we    = 1'b1;
            desc_waddr = t_ff;
            desc_wdata = {a2_ff, l2_ff, f2_ff, 16'd0};
            avail_we   = 1'b1;
            avail_wdata = 16'(h_ff);
         end
         S_FREE_RD: begin
            desc_raddr = cur_ff;
         end
         S_FREE_CHK: begin
            desc_we    = (total_ff < size_ff);
            desc_wdata = {112'd0, 16'(head_ff)};
         end
         S_TAKE: begin
         end
         default: begin
         end
      endcase
   end

   vqdm_ram #(.WIDTH(DESC_W), .DEPTH(QUEUE_DEPTH)) u_desc (
      .clock(clock), .wr_en(desc_we), .wr_addr(desc_waddr), .wr_data(desc_wdata),
      .rd_addr(desc_raddr), .rd_data(desc_rdata)
   );

   // avail ring is published for the driver side; nothing here reads it back
   vqdm_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_avail (
      .clock(clock), .wr_en(avail_we), .wr_addr(avail_waddr), .wr_data(avail_wdata),
      .rd_addr(avail_waddr), .rd_data(avail_unused)
   );

   vqdm_ram #(.WIDTH(USED_W), .DEPTH(QUEUE_DEPTH)) u_used (
      .clock(clock), .wr_en(used_we), .wr_addr(used_waddr), .wr_data(used_wdata),
      .rd_addr(used_raddr), .rd_data(used_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         req_size_ff   <= CSR_SIZE_RESET;
         size_ff       <= '0;
         total_ff      <= '0;
         head_ff       <= '0;
         avail_pos_ff  <= '0;
         used_pos_ff   <= '0;
         cons_pos_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= ST_OK;
         rsp_id_ff     <= '0;
         rsp_len_ff    <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            req_size_ff <= csr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  a1_ff <= req_first_addr;  l1_ff <= req_first_len;
                  f1_ff <= req_first_flags;
                  a2_ff <= req_second_addr; l2_ff <= req_second_len;
                  f2_ff <= req_second_flags;
                  rsp_status_ff <= ST_OK;
                  rsp_id_ff     <= '0;
                  rsp_len_ff    <= '0;
                  rsp_valid_ff  <= 1'b1;
                  if (req_opcode == OP_INIT) begin
                     if (!size_pow2) begin
                        rsp_status_ff <= ST_BAD_SIZE;
                     end else begin
                        rsp_valid_ff <= 1'b0;
                        cur_ff       <= '0;
                        init_size_ff <= ({1'b0, req_size_ff} > 17'(QUEUE_DEPTH)) ?
                                        CW'(QUEUE_DEPTH) : CW'(req_size_ff);
                        state_ff     <= S_SWEEP;
                     end
                  end else if (req_opcode <= OP_TAKE && size_ff == '0) begin
                     rsp_status_ff <= ST_NO_INIT;
                  end else begin
                     unique case (req_opcode) inside
                        OP_ADD_ONE, OP_ADD_PAIR: begin
                           if (total_ff < ((req_opcode == OP_ADD_ONE) ? CW'(1) : CW'(2))
                               || CW'(head_ff) >= size_ff) begin
                              rsp_status_ff <= ST_NO_FREE;
                           end else begin
                              rsp_valid_ff <= 1'b0;
                              state_ff <= (req_opcode == OP_ADD_ONE) ? S_ADD1 : S_PAIR_B;
                           end
                        end
                        OP_FREE: begin
                           if ({1'b0, req_desc_id} >= 17'(size_ff)) begin
                              rsp_status_ff <= ST_BAD_ID;
                           end else begin
                              rsp_valid_ff <= 1'b0;
                              cur_ff   <= AW'(req_desc_id);
                              step_ff  <= '0;
                              state_ff <= S_FREE_RD;
                           end
                        end
                        OP_COMPLETE: begin
                           if ({1'b0, pending} >= 17'(size_ff)) begin
                              rsp_status_ff <= ST_NO_FREE;
                           end else begin
                              used_pos_ff <= used_pos_ff + 16'd1;
                           end
                        end
                        OP_TAKE: begin
                           if (cons_pos_ff == used_pos_ff) begin
                              rsp_status_ff <= ST_NO_USED;
                           end else begin
                              rsp_valid_ff <= 1'b0;
                              state_ff     <= S_TAKE;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
            S_SWEEP: begin
               cur_ff <= cur_ff + AW'(1);
               if (CW'(cur_ff) == init_size_ff - CW'(1)) begin
                  size_ff      <= init_size_ff;
                  total_ff     <= init_size_ff;
                  head_ff      <= '0;
                  avail_pos_ff <= '0;
                  used_pos_ff  <= '0;
                  cons_pos_ff  <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_ADD1: begin
               head_ff      <= t_sel;
               total_ff     <= total_ff - CW'(1);
               avail_pos_ff <= avail_pos_ff + 16'd1;
               rsp_id_ff    <= 16'(head_ff);
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_PAIR_B: begin
               h_ff     <= head_ff;
               t_ff     <= t_sel;
               head_ff  <= t_sel;
               state_ff <= S_PAIR_C;
            end
            S_PAIR_C: begin
               head_ff  <= nxt_ok ? AW'(nx_t) : '0;
               total_ff <= total_ff - CW'(2);
               state_ff <= S_PAIR_D;
            end
            S_PAIR_D: begin
               avail_pos_ff <= avail_pos_ff + 16'd1;
               rsp_id_ff    <= 16'(h_ff);
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_FREE_RD: begin
               state_ff <= S_FREE_CHK;
            end
            S_FREE_CHK: begin
               if (total_ff >= size_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  head_ff  <= cur_ff;
                  total_ff <= total_ff + CW'(1);
                  // stop at chain end, a bad link, or a full walk
                  if ((desc_rdata[16] == 1'b0) || !nx_ok ||
                      step_ff == size_ff - CW'(1)) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     cur_ff   <= AW'(rd_next);
                     step_ff  <= step_ff + CW'(1);
                     state_ff <= S_FREE_RD;
                  end
               end
            end
            S_TAKE: begin
               rsp_id_ff    <= used_rdata[47:32];
               rsp_len_ff   <= used_rdata[31:0];
               cons_pos_ff  <= cons_pos_ff + 16'd1;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_id    = rsp_id_ff;
   assign rsp_result_len   = rsp_len_ff;
   assign rsp_used_pending = (cons_pos_ff != used_pos_ff);
   assign rsp_free_left    = 9'(total_ff);
   assign rsp_avail_index  = avail_pos_ff;

   a_busy_ends_in_beat: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("busy dropped without a response beat");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item neither worked nor answered");

   a_free_bounded: assert property (@(posedge clock) disable iff (reset)
      total_ff <= size_ff) else $error("free count exceeds ring size");

endmodule

// ----- src/vqdm_ram.sv -----
// ----------------------------------------------------------------------------
// vqdm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module vqdm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- bench/virtqueue_descriptor_manager_top_tb.sv -----
// ----------------------------------------------------------------------------
// virtqueue_descriptor_manager_top_tb: self-checking bench for the manager
// Drives command beats with random gaps, predicts every response from a
// local copy of the descriptor table, rings and free list, and compares each
// response field by field. The ring size register is swept between phases.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_manager_top_tb;
   import vqdm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 256;
   localparam int STALL_LIMIT = 20000;
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   typedef struct {
      logic [2:0]  op;
      logic [63:0] first_addr;
      logic [31:0] first_len;
      logic [15:0] first_flags;
      logic [63:0] second_addr;
      logic [31:0] second_len;
      logic [15:0] second_flags;
      logic [15:0] desc_id;
   } command_type;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] result_id;
      logic [31:0] result_len;
      logic        used_pending;
      logic [8:0]  free_left;
      logic [15:0] avail_index;
   } response_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_opcode;
   logic [63:0] req_first_addr;
   logic [31:0] req_first_len;
   logic [15:0] req_first_flags;
   logic [63:0] req_second_addr;
   logic [31:0] req_second_len;
   logic [15:0] req_second_flags;
   logic [15:0] req_desc_id;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_result_id;
   logic [31:0] rsp_result_len;
   logic        rsp_used_pending;
   logic [8:0]  rsp_free_left;
   logic [15:0] rsp_avail_index;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   virtqueue_descriptor_manager_top dut (.*);

   // shadow of the manager
   logic [63:0] sh_addr [DEPTH];
   logic [31:0] sh_len [DEPTH];
   logic [15:0] sh_flags [DEPTH];
   logic [15:0] sh_next [DEPTH];
   logic [15:0] sh_used_id [DEPTH];
   logic [31:0] sh_used_len [DEPTH];
   logic [15:0] ring_size_reg;
   int          live_size;
   int          free_head;
   int          free_count;
   logic [15:0] avail_pos;
   logic [15:0] used_pos;
   logic [15:0] taken_pos;

   command_type  pending_cmds[$];
   response_type expected_rsps[$];
   logic [15:0]  issued_heads[$];
   int           errors;
   int           checked;
   int           status_seen [8];
   int           stall_cycles;
   int           csr_beats;
   bit           cmd_beat;
   bit           burst_mode;
   int           gap_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pop_free();
      int d;
      int nx;
      d = free_head;
      nx = sh_next[d];
      free_head = (nx < live_size) ? nx : 0;
      free_count--;
      sh_next[d] = 16'd0;
      return d;
   endfunction

   function automatic void publish_head(int head);
      avail_pos = avail_pos + 16'd1;
      issued_heads.push_back(head[15:0]);
   endfunction

   function automatic void release_chain(int head);
      int cur;
      int nx;
      bit more;
      cur = head;
      for (int step = 0; step < live_size; step++) begin
         nx = sh_next[cur];
         more = (sh_flags[cur] & FLAG_NEXT) != 16'd0;
         if (free_count >= live_size) break;
         sh_addr[cur] = '0;
         sh_len[cur] = '0;
         sh_flags[cur] = '0;
         sh_next[cur] = free_head[15:0];
         free_head = cur;
         free_count++;
         if (!more || nx >= live_size) break;
         cur = nx;
      end
   endfunction

   function automatic response_type predict_response(command_type c);
      response_type r;
      int s;
      int h;
      int t;
      int slot;
      r = '{default: '0};
      r.status = ST_OK;
      if (c.op == OP_INIT) begin
         s = ring_size_reg;
         if (s == 0 || (s & (s - 1)) != 0) begin
            r.status = ST_BAD_SIZE;
         end else begin
            if (s > DEPTH) s = DEPTH;
            for (int i = 0; i < DEPTH; i++) begin
               sh_addr[i] = '0;
               sh_len[i] = '0;
               sh_flags[i] = '0;
               sh_next[i] = (i < s) ? 16'(i + 1) : 16'd0;
               sh_used_id[i] = '0;
               sh_used_len[i] = '0;
            end
            sh_next[s - 1] = END_MARK;
            live_size = s;
            free_head = 0;
            free_count = s;
            avail_pos = '0;
            used_pos = '0;
            taken_pos = '0;
            issued_heads.delete();
         end
      end else if (c.op <= OP_TAKE && live_size == 0) begin
         r.status = ST_NO_INIT;
      end else if (c.op == OP_ADD_ONE) begin
         if (free_count < 1 || free_head >= live_size) begin
            r.status = ST_NO_FREE;
         end else begin
            h = pop_free();
            sh_addr[h] = c.first_addr;
            sh_len[h] = c.first_len;
            sh_flags[h] = c.first_flags;
            sh_next[h] = '0;
            publish_head(h);
            r.result_id = h[15:0];
         end
      end else if (c.op == OP_ADD_PAIR) begin
         if (free_count < 2 || free_head >= live_size) begin
            r.status = ST_NO_FREE;
         end else begin
            h = pop_free();
            t = pop_free();
            sh_addr[h] = c.first_addr;
            sh_len[h] = c.first_len;
            sh_flags[h] = c.first_flags | FLAG_NEXT;
            sh_next[h] = t[15:0];
            sh_addr[t] = c.second_addr;
            sh_len[t] = c.second_len;
            sh_flags[t] = c.second_flags;
            sh_next[t] = '0;
            publish_head(h);
            r.result_id = h[15:0];
         end
      end else if (c.op == OP_FREE) begin
         if (c.desc_id >= live_size) r.status = ST_BAD_ID;
         else release_chain(c.desc_id);
      end else if (c.op == OP_COMPLETE) begin
         if (int'(16'(used_pos - taken_pos)) >= live_size) begin
            r.status = ST_NO_FREE;
         end else begin
            slot = used_pos % live_size;
            sh_used_id[slot] = c.desc_id;
            sh_used_len[slot] = c.first_len;
            used_pos = used_pos + 16'd1;
         end
      end else if (c.op == OP_TAKE) begin
         if (taken_pos == used_pos) begin
            r.status = ST_NO_USED;
         end else begin
            slot = taken_pos % live_size;
            r.result_id = sh_used_id[slot];
            r.result_len = sh_used_len[slot];
            taken_pos = taken_pos + 16'd1;
         end
      end
      r.used_pending = taken_pos != used_pos;
      r.free_left = free_count[8:0];
      r.avail_index = avail_pos;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic command_type make_cmd(logic [2:0] op, logic [15:0] id);
      command_type c;
      c.op = op;
      c.first_addr = rand64();
      c.first_len = $urandom();
      c.first_flags = 16'($urandom());
      c.second_addr = rand64();
      c.second_len = $urandom();
      c.second_flags = 16'($urandom());
      c.desc_id = id;
      return c;
   endfunction

   function automatic command_type random_cmd();
      int p;
      int k;
      logic [2:0] op;
      logic [15:0] id;
      p = $urandom_range(0, 99);
      if (p < 2) op = OP_INIT;
      else if (p < 4) op = ($urandom_range(0, 1) != 0) ? OP_SPARE_LO : OP_SPARE_HI;
      else if (p < 22) op = OP_ADD_ONE;
      else if (p < 40) op = OP_ADD_PAIR;
      else if (p < 60) op = OP_FREE;
      else if (p < 80) op = OP_COMPLETE;
      else op = OP_TAKE;
      id = 16'($urandom());
      k = $urandom_range(0, 9);
      // mostly reuse real chain heads so frees walk live chains and completions name real heads
      if (k < 7 && issued_heads.size() > 0) begin
         k = $urandom_range(0, issued_heads.size() - 1);
         id = issued_heads[k];
         if (op == OP_FREE) issued_heads.delete(k);
      end else if (k < 9 && live_size > 0) begin
         id = 16'($urandom_range(0, live_size - 1));
      end
      return make_cmd(op, id);
   endfunction

   function automatic int next_gap();
      int p;
      if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
      if (burst_mode) return 0;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // request driver
   always @(negedge clock) begin
      command_type c;
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else if (start && !cmd_beat) begin
         // hold the beat until accepted
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left--;
      end else if (pending_cmds.size() > 0) begin
         c = pending_cmds.pop_front();
         req_opcode <= c.op;
         req_first_addr <= c.first_addr;
         req_first_len <= c.first_len;
         req_first_flags <= c.first_flags;
         req_second_addr <= c.second_addr;
         req_second_len <= c.second_len;
         req_second_flags <= c.second_flags;
         req_desc_id <= c.desc_id;
         start <= 1'b1;
         gap_left = next_gap();
      end else begin
         start <= 1'b0;
      end
   end

   // accept beats, predict, check responses
   always @(posedge clock) begin
      command_type c;
      response_type e;
      bit moved;
      moved = 1'b0;
      cmd_beat = !reset && start && !busy;
      if (cmd_beat) begin
         c.op = req_opcode;
         c.first_addr = req_first_addr;
         c.first_len = req_first_len;
         c.first_flags = req_first_flags;
         c.second_addr = req_second_addr;
         c.second_len = req_second_len;
         c.second_flags = req_second_flags;
         c.desc_id = req_desc_id;
         expected_rsps.push_back(predict_response(c));
         moved = 1'b1;
      end
      if (!reset && csr_valid && csr_ready) begin
         ring_size_reg = csr_data;
         csr_beats++;
         moved = 1'b1;
      end
      if (!reset && rsp_valid) begin
         moved = 1'b1;
         if (expected_rsps.size() == 0) begin
            $error("response with nothing expected: status %0d", rsp_status);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            checked++;
            status_seen[e.status]++;
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_result_id !== e.result_id) begin
               $error("result_id exp %0d got %0d", e.result_id, rsp_result_id);
               errors++;
            end
            if (rsp_result_len !== e.result_len) begin
               $error("result_len exp %0h got %0h", e.result_len, rsp_result_len);
               errors++;
            end
            if (rsp_used_pending !== e.used_pending) begin
               $error("used_pending exp %0d got %0d", e.used_pending, rsp_used_pending);
               errors++;
            end
            if (rsp_free_left !== e.free_left) begin
               $error("free_left exp %0d got %0d", e.free_left, rsp_free_left);
               errors++;
            end
            if (rsp_avail_index !== e.avail_index) begin
               $error("avail_index exp %0d got %0d", e.avail_index, rsp_avail_index);
               errors++;
            end
         end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic drain();
      while (pending_cmds.size() > 0 || start || busy || expected_rsps.size() > 0)
         @(negedge clock);
   endtask

   task automatic write_size(logic [15:0] v);
      int n;
      n = csr_beats;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      while (csr_beats == n) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [15:0] sizes [9];
      int phase_len;
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      req_opcode = '0;
      req_first_addr = '0;
      req_first_len = '0;
      req_first_flags = '0;
      req_second_addr = '0;
      req_second_len = '0;
      req_second_flags = '0;
      req_desc_id = '0;
      errors = 0;
      checked = 0;
      stall_cycles = 0;
      csr_beats = 0;
      burst_mode = 1'b0;
      ring_size_reg = CSR_SIZE_RESET;
      live_size = 0;
      free_head = 0;
      free_count = 0;
      avail_pos = '0;
      used_pos = '0;
      taken_pos = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: before init, spare codes, extremes at the reset size
      for (int op = OP_ADD_ONE; op <= OP_TAKE; op++)
         pending_cmds.push_back(make_cmd(op[2:0], 16'd0));
      pending_cmds.push_back(make_cmd(OP_SPARE_LO, 16'd0));
      pending_cmds.push_back(make_cmd(OP_SPARE_HI, 16'hFFFF));
      pending_cmds.push_back(make_cmd(OP_INIT, 16'd0));
      pending_cmds.push_back(make_cmd(OP_TAKE, 16'd0));
      pending_cmds.push_back('{OP_ADD_ONE, '1, '1, 16'hFFFF, '1, '1, '1, 16'hFFFF});
      pending_cmds.push_back('{OP_ADD_PAIR, '0, '0, '0, '1, '1, 16'hFFFE, '0});
      pending_cmds.push_back('{OP_ADD_PAIR, '1, '1, 16'hFFFE, '0, '0, '0, '0});
      pending_cmds.push_back('{OP_COMPLETE, '0, '1, '0, '0, '0, '0, 16'hFFFF});
      pending_cmds.push_back('{OP_COMPLETE, '0, '0, '0, '0, '0, '0, 16'd0});
      pending_cmds.push_back(make_cmd(OP_TAKE, 16'd0));
      pending_cmds.push_back(make_cmd(OP_TAKE, 16'd0));
      pending_cmds.push_back(make_cmd(OP_FREE, 16'd1));
      pending_cmds.push_back(make_cmd(OP_FREE, 16'd0));
      pending_cmds.push_back(make_cmd(OP_FREE, 16'd256));
      pending_cmds.push_back(make_cmd(OP_FREE, 16'hFFFF));
      drain();

      // directed: tiny ring, fill used ring and run out of descriptors
      write_size(16'd2);
      pending_cmds.push_back(make_cmd(OP_INIT, 16'd0));
      repeat (3) pending_cmds.push_back(make_cmd(OP_COMPLETE, 16'd7));
      pending_cmds.push_back(make_cmd(OP_ADD_PAIR, 16'd0));
      pending_cmds.push_back(make_cmd(OP_ADD_ONE, 16'd0));
      pending_cmds.push_back(make_cmd(OP_FREE, 16'd0));
      pending_cmds.push_back(make_cmd(OP_FREE, 16'd1));
      drain();

      sizes = '{16'd1, 16'd4, 16'd16, 16'd32768, 16'd0, 16'd65535, 16'd8, 16'd3, 16'd256};
      foreach (sizes[i]) begin
         write_size(sizes[i]);
         pending_cmds.push_back(make_cmd(OP_INIT, 16'd0));
         phase_len = (sizes[i] >= 16'd256) ? 60 : 75;
         drain();
         // generate one command at a time so heads track the live table
         for (int n = 0; n < phase_len; n++) begin
            pending_cmds.push_back(random_cmd());
            while (pending_cmds.size() > 0) @(negedge clock);
         end
         drain();
      end

      repeat (20) @(negedge clock);
      $display("checked %0d responses over ring sizes 1 to 256 and rejected sizes", checked);
      $display("status counts ok %0d no_free %0d no_used %0d bad_size %0d bad_id %0d no_init %0d",
               status_seen[ST_OK], status_seen[ST_NO_FREE], status_seen[ST_NO_USED],
               status_seen[ST_BAD_SIZE], status_seen[ST_BAD_ID], status_seen[ST_NO_INIT]);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
